>>> sv/svc_pkg.sv
// svc_pkg: shared types, codes and helpers of the stereo channel vocoder
// depends on nothing; imported by every module and interface of the block
package svc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int STATE_FRAC     = 28;
  localparam int GAIN_FRAC      = 12;
  localparam int IN_SHIFT       = STATE_FRAC + 1 - SAMPLE_BITS;
  localparam int COEF_W         = 17;
  localparam int GAIN_W         = 15;
  localparam int IDX_W          = 5;
  localparam int REG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 17;

  localparam logic [31:0] LCG_INIT   = 32'd12345;
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;
  localparam logic [15:0] OUT_FULL   = 16'd32767;

  // request codes
  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_COEF  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_BAND_COUNT     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_Q_RECIP        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MODULATOR_GAIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_SCALE      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WET_MIX        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_NOISE_AMOUNT   = 3'd7;

  // sequencer steps, also the controller state codes
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_PRE1 = 5'd1;
  localparam logic [4:0] ST_PRE2 = 5'd2;
  localparam logic [4:0] ST_PRE3 = 5'd3;
  localparam logic [4:0] ST_RD   = 5'd4;
  localparam logic [4:0] ST_LD   = 5'd5;
  localparam logic [4:0] ST_M1   = 5'd6;
  localparam logic [4:0] ST_M2   = 5'd7;
  localparam logic [4:0] ST_M3   = 5'd8;
  localparam logic [4:0] ST_M4   = 5'd9;
  localparam logic [4:0] ST_C2   = 5'd10;
  localparam logic [4:0] ST_C3   = 5'd11;
  localparam logic [4:0] ST_C4   = 5'd12;
  localparam logic [4:0] ST_E    = 5'd13;
  localparam logic [4:0] ST_P    = 5'd14;
  localparam logic [4:0] ST_A    = 5'd15;
  localparam logic [4:0] ST_F1   = 5'd16;
  localparam logic [4:0] ST_F2   = 5'd17;
  localparam logic [4:0] ST_F3   = 5'd18;
  localparam logic [4:0] ST_F4   = 5'd19;
  localparam logic [4:0] ST_F5   = 5'd20;
  localparam logic [4:0] ST_F6   = 5'd21;
  localparam logic [4:0] ST_F7   = 5'd22;
  localparam logic [4:0] ST_F8   = 5'd23;

  typedef struct packed {
    logic [4:0] step;
    logic       latch;
    logic       coef_wr;
    logic       clear;
    logic       out_load;
  } svc_cmd_t;

  typedef struct packed {
    logic [1:0]        band_count_code;
    logic [COEF_W-1:0] band_q_recip;
    logic [COEF_W-1:0] attack_coeff;
    logic [COEF_W-1:0] release_coeff;
    logic [GAIN_W-1:0] modulator_gain;
    logic [GAIN_W-1:0] out_scale;
    logic [COEF_W-1:0] wet_mix;
    logic [COEF_W-1:0] noise_amount;
  } svc_cfg_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [SAMPLE_BITS-1:0] carrier_left;
    logic signed [SAMPLE_BITS-1:0] carrier_right;
    logic signed [SAMPLE_BITS-1:0] modulator_left;
    logic signed [SAMPLE_BITS-1:0] modulator_right;
    logic [IDX_W-1:0]         band_index;
    logic [COEF_W-1:0]        band_coef_value;
  } svc_payload_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = 32'(x);
    return r;
  endfunction

endpackage

>>> sv/svc_in_if.sv
// svc_in_if: input item channel of the vocoder
// depends on svc_pkg for field widths
interface svc_in_if;
  import svc_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [SAMPLE_BITS-1:0] carrier_left;
  logic signed [SAMPLE_BITS-1:0] carrier_right;
  logic signed [SAMPLE_BITS-1:0] modulator_left;
  logic signed [SAMPLE_BITS-1:0] modulator_right;
  logic [IDX_W-1:0]              band_index;
  logic [COEF_W-1:0]             band_coef_value;
  modport source(output valid, req_type, carrier_left, carrier_right, modulator_left,
                 modulator_right, band_index, band_coef_value, input ready);
  modport sink(input valid, req_type, carrier_left, carrier_right, modulator_left,
               modulator_right, band_index, band_coef_value, output ready);
endinterface

>>> sv/svc_out_if.sv
// svc_out_if: result channel of the vocoder
// depends on svc_pkg for field widths
interface svc_out_if;
  import svc_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  modport source(output valid, out_left, out_right, input ready);
  modport sink(input valid, out_left, out_right, output ready);
endinterface

>>> sv/svc_cfg_if.sv
// svc_cfg_if: register write channel of the vocoder
// depends on svc_pkg for index and data widths
interface svc_cfg_if;
  import svc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> sv/stereo_channel_vocoder.sv
// stereo_channel_vocoder: channel vocoder top level, controller plus datapath
// depends on svc_pkg, the channel interfaces, svc_ctrl and svc_datapath
//
// usage
// - in_ch carries items: req_type frame, band coefficient write or state clear
// - out_ch gives one stereo sample per frame item, nothing for other items
// - cfg_ch writes the eight registers; always ready, write only while idle
// - a frame runs the preparation steps, the band steps once per active band
//   (8 to 32 bands) and the finish steps up to output valid; a new frame is
//   accepted only in idle; two channel lanes each step their own shared
//   multiplier through every filter, follower and product
// - coefficient writes and clears are done when accepted and leave the sequencer idle
// - the next item is accepted while a finished sample waits on out_ch; a
//   stalled receiver only holds a following frame at its last step
// - reset loads the register defaults, seeds the noise generator and marks
//   all band states as zero through per band valid bits; coefficients stay
//   undefined until written
module stereo_channel_vocoder #(
  parameter int MAX_BAND_COUNT = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  svc_in_if.sink   in_ch,
  svc_out_if.source out_ch,
  svc_cfg_if.sink  cfg_ch
);
  import svc_pkg::*;

  svc_cmd_t cmd;
  svc_payload_t pl;
  logic [$clog2(MAX_BAND_COUNT)-1:0] band;
  logic [1:0] band_count_code;

  // item payload gathered for the datapath
  assign pl.req_type        = in_ch.req_type;
  assign pl.carrier_left    = in_ch.carrier_left;
  assign pl.carrier_right   = in_ch.carrier_right;
  assign pl.modulator_left  = in_ch.modulator_left;
  assign pl.modulator_right = in_ch.modulator_right;
  assign pl.band_index      = in_ch.band_index;
  assign pl.band_coef_value = in_ch.band_coef_value;

  svc_ctrl #(.MAX_BAND_COUNT(MAX_BAND_COUNT)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_req(in_ch.req_type), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .band_count_code(band_count_code), .cmd(cmd), .band(band)
  );

  // output sample registers live in the datapath and hold until transfer
  svc_datapath #(.MAX_BAND_COUNT(MAX_BAND_COUNT)) u_datapath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .band(band), .pl(pl), .cfg_ch(cfg_ch),
    .band_count_code(band_count_code),
    .res_left(out_ch.out_left), .res_right(out_ch.out_right)
  );

endmodule

>>> sv/svc_lane.sv
// svc_lane: one stereo channel of the vocoder datapath, band state memory,
// shared multiplier and accumulator; depends on svc_pkg
module svc_lane #(
  parameter int MAX_BAND_COUNT = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  svc_pkg::svc_cmd_t                      cmd,
  input  logic [$clog2(MAX_BAND_COUNT)-1:0]      band,
  input  svc_pkg::svc_cfg_t                      cfg,
  input  logic [svc_pkg::COEF_W-1:0]             freq,
  input  logic [svc_pkg::COEF_W-1:0]             wet,
  input  logic [svc_pkg::COEF_W-1:0]             dry,
  input  logic signed [svc_pkg::SAMPLE_BITS-1:0] mod_sample,
  input  logic signed [svc_pkg::SAMPLE_BITS-1:0] car_sample,
  input  logic signed [31:0]                     noise_add,
  output logic signed [svc_pkg::SAMPLE_BITS-1:0] res
);
  import svc_pkg::*;

  localparam int ACC_W = 36 + $clog2(MAX_BAND_COUNT);
  localparam int ROW_W = 5 * 32;
  localparam int X_W   = SAMPLE_BITS + IN_SHIFT;

  logic [ROW_W-1:0] row_mem [MAX_BAND_COUNT];
  logic [ROW_W-1:0] row_rd_r;
  logic [MAX_BAND_COUNT-1:0] vld_r;
  logic vld_rd_r;

  logic signed [31:0] in_m_r, in_c_r, lm_r, bm_r, lc_r, bc_r, env_r, scl_r;
  logic signed [X_W-1:0] dry_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [63:0] tmp_r;
  logic signed [29:0] mcl_r;
  logic signed [66:0] prod_r;

  logic signed [32:0] op_a;
  logic signed [33:0] op_b;
  logic signed [63:0] p12, p16, p28, fin_sum, mix;
  logic signed [31:0] hm, hc;
  logic signed [32:0] rect;
  logic signed [33:0] diff;
  logic signed [X_W-1:0] mod_x, car_x;
  logic signed [66:0] rnd;

  always_comb begin
    p12 = 64'(prod_r >>> GAIN_FRAC);
    p16 = 64'(prod_r >>> COEF_FRAC_BITS);
    p28 = 64'(prod_r >>> STATE_FRAC);
    mod_x = X_W'(mod_sample) <<< IN_SHIFT;
    car_x = X_W'(car_sample) <<< IN_SHIFT;
    hm = sat32(64'(in_m_r) - 64'(lm_r) - p16);
    hc = sat32(64'(in_c_r) - 64'(lc_r) - p16);
    rect = bm_r[31] ? -33'(bm_r) : 33'(bm_r);
    diff = 34'(rect) - 34'(env_r);
    fin_sum = (64'(signed'(prod_r[39:0])) <<< 20) + tmp_r;
    mix = tmp_r + p16;
    rnd = prod_r + (prod_r[66] ? 67'sd268435455 : 67'sd0);
    res = SAMPLE_BITS'(rnd >>> STATE_FRAC);
    op_a = '0;
    op_b = '0;
    case (cmd.step)
      ST_PRE1: begin
        op_a = 33'(mod_x);
        op_b = 34'($signed({1'b0, cfg.modulator_gain}));
      end
      ST_M1: begin
        op_a = 33'($signed({1'b0, freq}));
        op_b = 34'(bm_r);
      end
      ST_M2: begin
        op_a = 33'($signed({1'b0, cfg.band_q_recip}));
        op_b = 34'(bm_r);
      end
      ST_M3: begin
        op_a = 33'($signed({1'b0, freq}));
        op_b = 34'(hm);
      end
      ST_M4: begin
        op_a = 33'($signed({1'b0, freq}));
        op_b = 34'(bc_r);
      end
      ST_C2: begin
        op_a = 33'($signed({1'b0, cfg.band_q_recip}));
        op_b = 34'(bc_r);
      end
      ST_C3: begin
        op_a = 33'($signed({1'b0, freq}));
        op_b = 34'(hc);
      end
      ST_C4: begin
        // attack when the rectified band rises above the envelope
        op_a = (diff > 34'sd0) ? 33'($signed({1'b0, cfg.attack_coeff}))
                               : 33'($signed({1'b0, cfg.release_coeff}));
        op_b = diff;
      end
      ST_P: begin
        op_a = 33'(bc_r);
        op_b = 34'(env_r);
      end
      ST_F1: begin
        op_a = 33'($signed({1'b0, acc_r[19:0]}));
        op_b = 34'($signed({1'b0, cfg.out_scale}));
      end
      ST_F2: begin
        op_a = 33'(signed'(acc_r[ACC_W-1:20]));
        op_b = 34'($signed({1'b0, cfg.out_scale}));
      end
      ST_F4: begin
        op_a = 33'($signed({1'b0, wet}));
        op_b = 34'(scl_r);
      end
      ST_F5: begin
        op_a = 33'($signed({1'b0, dry}));
        op_b = 34'(dry_r);
      end
      ST_F7, ST_F8: begin
        op_a = 33'(mcl_r);
        op_b = 34'($signed({1'b0, OUT_FULL}));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r   <= op_a * op_b;
    row_rd_r <= row_mem[band];
    vld_rd_r <= vld_r[band];
    if (cmd.step == ST_A) begin
      row_mem[band] <= {lm_r, bm_r, lc_r, bc_r, env_r};
    end
    case (cmd.step)
      ST_PRE1: begin
        dry_r <= car_x;
        acc_r <= '0;
      end
      ST_PRE2: in_m_r <= sat32(p12);
      ST_PRE3: in_c_r <= sat32(64'(dry_r) + 64'(noise_add));
      ST_LD: begin
        if (vld_rd_r) begin
          {lm_r, bm_r, lc_r, bc_r, env_r} <= row_rd_r;
        end else begin
          {lm_r, bm_r, lc_r, bc_r, env_r} <= '0;
        end
      end
      ST_M2: lm_r  <= sat32(64'(lm_r) + p16);
      ST_M4: bm_r  <= sat32(64'(bm_r) + p16);
      ST_C2: lc_r  <= sat32(64'(lc_r) + p16);
      ST_C4: bc_r  <= sat32(64'(bc_r) + p16);
      ST_E:  env_r <= sat32(64'(env_r) + p16);
      ST_A:  acc_r <= acc_r + ACC_W'(p28);
      ST_F2: tmp_r <= 64'(prod_r);
      ST_F3: scl_r <= sat32(fin_sum >>> GAIN_FRAC);
      ST_F5: tmp_r <= p16;
      ST_F6: begin
        if (mix > 64'sd268435456) mcl_r <= 30'sd268435456;
        else if (mix < -64'sd268435456) mcl_r <= -30'sd268435456;
        else mcl_r <= 30'(mix);
      end
      default: ;
    endcase
  end

  // valid bits stand for the zero reset of the band states
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r <= '0;
    end else if (cmd.step == ST_A) begin
      vld_r[band] <= 1'b1;
    end
  end

endmodule

>>> sv/svc_datapath.sv
// svc_datapath: registers, coefficient memory, noise source and both lanes
// depends on svc_pkg, svc_cfg_if and svc_lane
module svc_datapath #(
  parameter int MAX_BAND_COUNT = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  svc_pkg::svc_cmd_t                      cmd,
  input  logic [$clog2(MAX_BAND_COUNT)-1:0]      band,
  input  svc_pkg::svc_payload_t                  pl,
  svc_cfg_if.sink                                cfg_ch,
  output logic [1:0]                             band_count_code,
  output logic signed [svc_pkg::SAMPLE_BITS-1:0] res_left,
  output logic signed [svc_pkg::SAMPLE_BITS-1:0] res_right
);
  import svc_pkg::*;

  localparam int AW = $clog2(MAX_BAND_COUNT);

  svc_cfg_t cfg_r;
  logic [COEF_W-1:0] coef_mem [MAX_BAND_COUNT];
  logic [COEF_W-1:0] coef_rd_r, freq_r, wet, dry;
  logic [31:0] noise_r;
  logic signed [31:0] nsm_r;
  logic signed [SAMPLE_BITS-1:0] car_l_r, car_r_r, mod_l_r, mod_r_r;
  logic signed [SAMPLE_BITS-1:0] lane_l, lane_r;
  logic signed [47:0] nprod;

  assign cfg_ch.ready    = 1'b1;
  assign band_count_code = cfg_r.band_count_code;
  assign wet   = (cfg_r.wet_mix > COEF_ONE) ? COEF_ONE : cfg_r.wet_mix;
  assign dry   = COEF_ONE - wet;
  assign nprod = 48'($signed(noise_r) >>> 3) * 48'($signed({1'b0, cfg_r.noise_amount}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_count_code <= 2'd1;
      cfg_r.band_q_recip    <= 17'd20480;
      cfg_r.attack_coeff    <= 17'd297;
      cfg_r.release_coeff   <= 17'd30;
      cfg_r.modulator_gain  <= 15'd8192;
      cfg_r.out_scale       <= 15'd8192;
      cfg_r.wet_mix         <= 17'd65536;
      cfg_r.noise_amount    <= 17'd6554;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BAND_COUNT:     cfg_r.band_count_code <= cfg_ch.data[1:0];
        REG_Q_RECIP:        cfg_r.band_q_recip    <= cfg_ch.data;
        REG_ATTACK:         cfg_r.attack_coeff    <= cfg_ch.data;
        REG_RELEASE:        cfg_r.release_coeff   <= cfg_ch.data;
        REG_MODULATOR_GAIN: cfg_r.modulator_gain  <= cfg_ch.data[GAIN_W-1:0];
        REG_OUT_SCALE:      cfg_r.out_scale       <= cfg_ch.data[GAIN_W-1:0];
        REG_WET_MIX:        cfg_r.wet_mix         <= cfg_ch.data;
        REG_NOISE_AMOUNT:   cfg_r.noise_amount    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // lcg noise, one step per frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= LCG_INIT;
    end else if (cmd.step == ST_PRE1) begin
      noise_r <= noise_r * LCG_MUL + LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    coef_rd_r <= coef_mem[band];
    if (cmd.coef_wr && (int'(pl.band_index) < MAX_BAND_COUNT)) begin
      coef_mem[AW'(pl.band_index)] <= pl.band_coef_value;
    end
    if (cmd.step == ST_LD) freq_r <= coef_rd_r;
    if (cmd.step == ST_PRE2) nsm_r <= 32'(nprod >>> COEF_FRAC_BITS);
    if (cmd.latch) begin
      car_l_r <= pl.carrier_left;
      car_r_r <= pl.carrier_right;
      mod_l_r <= pl.modulator_left;
      mod_r_r <= pl.modulator_right;
    end
    if (cmd.out_load) begin
      res_left  <= lane_l;
      res_right <= lane_r;
    end
  end

  svc_lane #(.MAX_BAND_COUNT(MAX_BAND_COUNT)) u_lane_left (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .band(band), .cfg(cfg_r), .freq(freq_r),
    .wet(wet), .dry(dry), .mod_sample(mod_l_r), .car_sample(car_l_r),
    .noise_add(nsm_r), .res(lane_l)
  );

  svc_lane #(.MAX_BAND_COUNT(MAX_BAND_COUNT)) u_lane_right (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .band(band), .cfg(cfg_r), .freq(freq_r),
    .wet(wet), .dry(dry), .mod_sample(mod_r_r), .car_sample(car_r_r),
    .noise_add(nsm_r), .res(lane_r)
  );

endmodule

>>> sv/svc_ctrl.sv
// svc_ctrl: sequencer of the vocoder, steps through preparation, bands and finish
// depends on svc_pkg
module svc_ctrl #(
  parameter int MAX_BAND_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [1:0]                        in_req,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  logic [1:0]                        band_count_code,
  output svc_pkg::svc_cmd_t                 cmd,
  output logic [$clog2(MAX_BAND_COUNT)-1:0] band
);
  import svc_pkg::*;

  localparam int AW = $clog2(MAX_BAND_COUNT);

  logic [4:0] state_r, state_nxt;
  logic [AW-1:0] band_r, band_nxt, last_band;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  int nb;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign band      = band_r;

  always_comb begin
    nb = 8 * (int'(band_count_code) + 1);
    if (nb > MAX_BAND_COUNT) nb = MAX_BAND_COUNT;
    last_band = AW'(nb - 1);
  end

  always_comb begin
    state_nxt     = state_r;
    band_nxt      = band_r;
    cmd.step      = state_r;
    cmd.latch     = 1'b0;
    cmd.coef_wr   = 1'b0;
    cmd.clear     = 1'b0;
    cmd.out_load  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          band_nxt = '0;
          case (in_req)
            REQ_FRAME: begin
              cmd.latch = 1'b1;
              state_nxt = ST_PRE1;
            end
            REQ_COEF:  cmd.coef_wr = 1'b1;
            REQ_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_PRE1: state_nxt = ST_PRE2;
      ST_PRE2: state_nxt = ST_PRE3;
      ST_PRE3: state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_LD;
      ST_LD:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_C2;
      ST_C2:   state_nxt = ST_C3;
      ST_C3:   state_nxt = ST_C4;
      ST_C4:   state_nxt = ST_E;
      ST_E:    state_nxt = ST_P;
      ST_P:    state_nxt = ST_A;
      ST_A: begin
        if (band_r == last_band) begin
          state_nxt = ST_F1;
        end else begin
          band_nxt  = band_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_F1: state_nxt = ST_F2;
      ST_F2: state_nxt = ST_F3;
      ST_F3: state_nxt = ST_F4;
      ST_F4: state_nxt = ST_F5;
      ST_F5: state_nxt = ST_F6;
      ST_F6: state_nxt = ST_F7;
      ST_F7: state_nxt = ST_F8;
      ST_F8: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      band_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      band_r      <= band_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (state_r == ST_IDLE && !out_valid_r))
    else $error("sequencer not idle after reset");
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req == REQ_FRAME) |=> (state_r == ST_PRE1))
    else $error("frame transfer did not start the sequence");
  a_band_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_A) |-> (band_r <= last_band))
    else $error("band counter ran past the active bands");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");
`endif

endmodule
